>>> hw/rtl/adcrp_pkg.sv
// Shared types and constants for the ADC capture rate planner.
// Depends on nothing; used by adcrp_div and adc_capture_rate_planner.
package adcrp_pkg;

  // Divider widths: 33-bit dividend, 32-bit divisor
  localparam int unsigned DVD_W = 33;
  localparam int unsigned DVS_W = 32;

  // Reset value of the system clock register
  localparam logic [31:0] CLK_RESET_HZ = 32'd100000000;

  // Count bounds
  localparam logic [19:0] COUNT_LIMIT = 20'd65535;

  // Sample-time half-cycles plus 25 conversion half-cycles, per setting
  localparam logic [9:0] SMP_LIMIT [8] = '{
    10'd28, 10'd40, 10'd52, 10'd82, 10'd108, 10'd136, 10'd168, 10'd504
  };

  // Top rate divisor: shortest setting plus conversion half-cycles
  localparam logic [31:0] MAX_RATE_DIV = 32'd28;

  // Result status codes
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_BAD_COUNT = 2'd1;
  localparam logic [1:0] STAT_BAD_RATE  = 2'd2;
  localparam logic [1:0] STAT_TOO_FAST  = 2'd3;

  // Input beat
  typedef struct packed {
    logic signed [31:0] rate_hz;
    logic [19:0]        sample_count;
  } in_t;

  // Result beat
  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  sample_setting;
    logic [15:0] prescaler;
    logic [15:0] reload;
    logic [25:0] max_rate_hz;
  } out_t;

  // Divider launch
  typedef struct packed {
    logic             go;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  // Divider completion
  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

endpackage

>>> hw/rtl/adcrp_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on adcrp_pkg for widths and the request/response structs.
module adcrp_div (
  input  logic                clk,
  input  logic                rst_n,
  input  adcrp_pkg::div_req_t req,
  output adcrp_pkg::div_rsp_t rsp
);

  localparam int unsigned CNT_W = $clog2(adcrp_pkg::DVD_W + 1);

  logic [adcrp_pkg::DVS_W-1:0] rem_r, rem_nxt;
  logic [adcrp_pkg::DVD_W-1:0] quo_r, quo_nxt;
  logic [adcrp_pkg::DVS_W-1:0] dvs_r;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic                        run_r, run_nxt;
  logic                        done_r, done_nxt;

  logic [adcrp_pkg::DVS_W:0]   trial;
  logic [adcrp_pkg::DVS_W+1:0] diff;

  // Shift one dividend bit into the remainder and try the subtract
  always_comb begin
    trial = {rem_r, quo_r[adcrp_pkg::DVD_W-1]};
    diff  = {1'b0, trial} - {2'b00, dvs_r};
  end

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (req.go) begin
      rem_nxt = '0;
      quo_nxt = req.dividend;
      cnt_nxt = CNT_W'(adcrp_pkg::DVD_W);
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (!diff[adcrp_pkg::DVS_W+1]) begin
        rem_nxt = diff[adcrp_pkg::DVS_W-1:0];
        quo_nxt = {quo_r[adcrp_pkg::DVD_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[adcrp_pkg::DVS_W-1:0];
        quo_nxt = {quo_r[adcrp_pkg::DVD_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (req.go) begin
      dvs_r <= req.divisor;
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

`ifndef ASSERT_OFF
  a_go_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.go |-> !run_r)
    else $error("divider launched while running");
  a_done_after_run: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !run_r && $past(run_r))
    else $error("divider done without a run");
  a_cnt_live: assert property (@(posedge clk) disable iff (!rst_n)
    run_r |-> cnt_r != '0)
    else $error("divider running with empty count");
`endif

endmodule

>>> hw/rtl/adc_capture_rate_planner.sv
// Top level of the ADC capture rate planner: checks, sample-time pick, timer plan.
// Depends on adcrp_pkg and instantiates adcrp_div.
//
//  channel  ports                       handshake
//  input    in_data                     start & !busy
//  result   out_data                    out_strobe, one cycle, no stall
//  config   cfg_wdata                   cfg_we
//
// A bad count or rate gives its result in the cycle after acceptance. A rate too
// high takes 2 divides and a good plan takes 4 divides; the next beat can be
// taken while the result is shown. Each divide is 33 steps of the shared
// radix-2 divider. Reset is synchronous and returns to idle with the clock
// register at 100 MHz. Results cannot stall.
module adc_capture_rate_planner (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  adcrp_pkg::in_t      in_data,
  output logic                out_strobe,
  output adcrp_pkg::out_t     out_data,
  input  logic                cfg_we,
  input  logic [31:0]         cfg_wdata
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_HALF = 6'b000010,
    S_PSC  = 6'b000100,
    S_Q    = 6'b001000,
    S_PER  = 6'b010000,
    S_MAX  = 6'b100000
  } state_t;

  state_t               state_r, state_nxt;
  logic [31:0]          sysclk_r;
  logic [30:0]          rate_r, rate_nxt;
  logic [2:0]           pick_r, pick_nxt;
  logic [15:0]          psc_r, psc_nxt;
  logic                 strobe_r, strobe_nxt;
  adcrp_pkg::out_t      out_r, out_nxt;

  adcrp_pkg::div_req_t  div_req;
  adcrp_pkg::div_rsp_t  div_rsp;

  logic                 fit;
  logic [2:0]           fit_idx;
  logic [32:0]          two_conv;
  logic [16:0]          period;

  // Twice the converter clock
  assign two_conv = {3'b000, sysclk_r[31:3], 1'b0};

  // Pick the longest sample setting that fits the half-cycle count
  always_comb begin
    fit     = 1'b0;
    fit_idx = '0;
    for (int i = 0; i < 8; i++) begin
      if (div_rsp.quotient >= {23'd0, adcrp_pkg::SMP_LIMIT[i]}) begin
        fit     = 1'b1;
        fit_idx = 3'(i);
      end
    end
  end

  // Clamp the timer period to at least 2
  always_comb begin
    period = div_rsp.quotient[16:0];
    if (period < 17'd2) begin
      period = 17'd2;
    end
  end

  // Sequence the divides
  always_comb begin
    state_nxt        = state_r;
    rate_nxt         = rate_r;
    pick_nxt         = pick_r;
    psc_nxt          = psc_r;
    strobe_nxt       = 1'b0;
    out_nxt          = out_r;
    div_req.go       = 1'b0;
    div_req.dividend = two_conv;
    div_req.divisor  = {1'b0, rate_r};
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          out_nxt = '0;
          if (in_data.sample_count == '0 ||
              in_data.sample_count > adcrp_pkg::COUNT_LIMIT) begin
            out_nxt.status = adcrp_pkg::STAT_BAD_COUNT;
            strobe_nxt     = 1'b1;
          end else if (in_data.rate_hz[31] || in_data.rate_hz == '0) begin
            out_nxt.status = adcrp_pkg::STAT_BAD_RATE;
            strobe_nxt     = 1'b1;
          end else begin
            rate_nxt        = in_data.rate_hz[30:0];
            div_req.go      = 1'b1;
            div_req.divisor = {1'b0, in_data.rate_hz[30:0]};
            state_nxt       = S_HALF;
          end
        end
      end
      S_HALF: begin
        if (div_rsp.done) begin
          div_req.go = 1'b1;
          if (fit) begin
            pick_nxt         = fit_idx;
            div_req.dividend = {1'b0, sysclk_r};
            state_nxt        = S_PSC;
          end else begin
            div_req.divisor = adcrp_pkg::MAX_RATE_DIV;
            state_nxt       = S_MAX;
          end
        end
      end
      S_PSC: begin
        if (div_rsp.done) begin
          psc_nxt          = div_rsp.quotient[31:16];
          div_req.go       = 1'b1;
          div_req.dividend = {1'b0, sysclk_r};
          div_req.divisor  = {15'd0, {1'b0, div_rsp.quotient[31:16]} + 17'd1};
          state_nxt        = S_Q;
        end
      end
      S_Q: begin
        if (div_rsp.done) begin
          div_req.go       = 1'b1;
          div_req.dividend = {1'b0, div_rsp.quotient[31:0]} + {3'b000, rate_r[30:1]};
          state_nxt        = S_PER;
        end
      end
      S_PER: begin
        if (div_rsp.done) begin
          out_nxt.status         = adcrp_pkg::STAT_OK;
          out_nxt.sample_setting = pick_r;
          out_nxt.prescaler      = psc_r;
          out_nxt.reload         = 16'(period - 17'd1);
          out_nxt.max_rate_hz    = '0;
          strobe_nxt             = 1'b1;
          state_nxt              = S_IDLE;
        end
      end
      S_MAX: begin
        if (div_rsp.done) begin
          out_nxt.status      = adcrp_pkg::STAT_TOO_FAST;
          out_nxt.max_rate_hz = div_rsp.quotient[25:0];
          strobe_nxt          = 1'b1;
          state_nxt           = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state and config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      strobe_r <= 1'b0;
      sysclk_r <= adcrp_pkg::CLK_RESET_HZ;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= strobe_nxt;
      if (cfg_we) begin
        sysclk_r <= cfg_wdata;
      end
    end
  end

  // Hold operands and the result beat
  always_ff @(posedge clk) begin
    rate_r <= rate_nxt;
    pick_r <= pick_nxt;
    psc_r  <= psc_nxt;
    out_r  <= out_nxt;
  end

  adcrp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = strobe_r;
  assign out_data   = out_r;

`ifndef ASSERT_OFF
  a_accept_moves: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy || out_strobe)
    else $error("accepted beat neither started nor answered");
  a_done_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> busy)
    else $error("divider finished while idle");
  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_data.status != adcrp_pkg::STAT_OK |->
      out_data.prescaler == '0 && out_data.reload == '0)
    else $error("error beat carries a timer plan");
  a_ok_reload: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_data.status == adcrp_pkg::STAT_OK |->
      out_data.reload != '0 && out_data.max_rate_hz == '0)
    else $error("ok beat with period below two");
`endif

endmodule

>>> test/adcrp_plan_checker.sv
// Scoreboard for the ADC capture rate planner: predicts each plan and checks result beats.
// Depends on adcrp_pkg; instantiated beside the block by adc_capture_rate_planner_tb.
`timescale 1ns / 1ps

module adcrp_plan_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                busy,
  input  adcrp_pkg::in_t      in_data,
  input  logic                out_strobe,
  input  adcrp_pkg::out_t     out_data,
  input  logic                cfg_we,
  input  logic [31:0]         cfg_wdata,
  input  logic                drain_done,
  output int unsigned         mismatch_count,
  output int unsigned         plans_pending
);

  // One accepted request and the plan it must produce
  typedef struct packed {
    adcrp_pkg::in_t  beat;
    adcrp_pkg::out_t plan;
  } pending_plan_t;

  logic [31:0]   sys_clock_hz = adcrp_pkg::CLK_RESET_HZ;
  pending_plan_t plan_queue [$];
  int unsigned   fail_tally = 0;
  bit            leftovers_flagged = 1'b0;

  // Print one line per mismatch and count it
  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    fail_tally++;
  endtask

  // Work out the capture plan for one request at the given bus clock
  function automatic adcrp_pkg::out_t plan_capture(input adcrp_pkg::in_t beat,
                                                   input logic [31:0] bus_hz);
    int unsigned     settle_halves [8] = '{3, 15, 27, 57, 83, 111, 143, 479};
    adcrp_pkg::out_t plan;
    logic [63:0]     conv_hz, rate, halves, psc, tick_hz, period;
    int              pick;
    plan = '0;
    pick = -1;
    if (beat.sample_count == 20'd0 || beat.sample_count > 20'd65535) begin
      plan.status = adcrp_pkg::STAT_BAD_COUNT;
    end else if ($signed(beat.rate_hz) <= 0) begin
      plan.status = adcrp_pkg::STAT_BAD_RATE;
    end else begin
      conv_hz = {32'd0, bus_hz} / 64'd8;
      rate    = {32'd0, beat.rate_hz};
      halves  = (64'd2 * conv_hz) / rate;
      // take the longest sample time that still fits one trigger period
      for (int i = 7; i >= 0; i--) begin
        if (pick < 0 && 64'(settle_halves[i]) + 64'd25 <= halves) begin
          pick = i;
        end
      end
      if (pick < 0) begin
        plan.status      = adcrp_pkg::STAT_TOO_FAST;
        plan.max_rate_hz = 26'((64'd2 * conv_hz) / 64'd28);
      end else begin
        // smallest prescaler keeping the count in 16 bits, then a rounded period
        psc     = {32'd0, bus_hz} / (64'd65536 * rate);
        tick_hz = {32'd0, bus_hz} / (psc + 64'd1);
        period  = (tick_hz + rate / 64'd2) / rate;
        if (period < 64'd2) begin
          period = 64'd2;
        end
        plan.status         = adcrp_pkg::STAT_OK;
        plan.sample_setting = 3'(pick);
        plan.prescaler      = psc[15:0];
        plan.reload         = 16'(period - 64'd1);
      end
    end
    return plan;
  endfunction

  always @(posedge clk) begin
    pending_plan_t head;
    pending_plan_t entry;
    if (!rst_n) begin
      sys_clock_hz = adcrp_pkg::CLK_RESET_HZ;
      plan_queue.delete();
    end else begin
      // check the result beat against the oldest plan
      if (out_strobe) begin
        if (plan_queue.size() == 0) begin
          report_mismatch("result beat with no plan outstanding");
        end else begin
          head = plan_queue.pop_front();
          if (out_data.status !== head.plan.status)
            report_mismatch($sformatf("rate %0d count %0d: status %0d, want %0d",
              $signed(head.beat.rate_hz), head.beat.sample_count,
              out_data.status, head.plan.status));
          if (out_data.sample_setting !== head.plan.sample_setting)
            report_mismatch($sformatf("rate %0d count %0d: sample_setting %0d, want %0d",
              $signed(head.beat.rate_hz), head.beat.sample_count,
              out_data.sample_setting, head.plan.sample_setting));
          if (out_data.prescaler !== head.plan.prescaler)
            report_mismatch($sformatf("rate %0d count %0d: prescaler %0d, want %0d",
              $signed(head.beat.rate_hz), head.beat.sample_count,
              out_data.prescaler, head.plan.prescaler));
          if (out_data.reload !== head.plan.reload)
            report_mismatch($sformatf("rate %0d count %0d: reload %0d, want %0d",
              $signed(head.beat.rate_hz), head.beat.sample_count,
              out_data.reload, head.plan.reload));
          if (out_data.max_rate_hz !== head.plan.max_rate_hz)
            report_mismatch($sformatf("rate %0d count %0d: max_rate_hz %0d, want %0d",
              $signed(head.beat.rate_hz), head.beat.sample_count,
              out_data.max_rate_hz, head.plan.max_rate_hz));
        end
      end
      // predict the plan for an accepted input beat
      if (start && !busy) begin
        entry.beat = in_data;
        entry.plan = plan_capture(in_data, sys_clock_hz);
        plan_queue.push_back(entry);
      end
      // track the bus clock register
      if (cfg_we) begin
        sys_clock_hz = cfg_wdata;
      end
      // flag plans that never came back
      if (drain_done && !leftovers_flagged) begin
        leftovers_flagged = 1'b1;
        foreach (plan_queue[i])
          report_mismatch($sformatf("no result for rate %0d count %0d",
            $signed(plan_queue[i].beat.rate_hz), plan_queue[i].beat.sample_count));
      end
    end
    plans_pending  <= plan_queue.size();
    mismatch_count <= fail_tally;
  end

endmodule

>>> test/adc_capture_rate_planner_tb.sv
// Testbench top for the ADC capture rate planner: clock, reset, stimulus and verdict.
// Depends on adcrp_pkg, adc_capture_rate_planner and adcrp_plan_checker.
`timescale 1ns / 1ps

module adc_capture_rate_planner_tb;

  logic            clk = 1'b0;
  logic            rst_n;
  logic            start;
  logic            busy;
  adcrp_pkg::in_t  in_data;
  logic            out_strobe;
  adcrp_pkg::out_t out_data;
  logic            cfg_we;
  logic [31:0]     cfg_wdata;
  logic            drain_done;
  int unsigned     mismatch_count;
  int unsigned     plans_pending;

  logic [31:0]     clock_setting;
  bit              quiet;

  adc_capture_rate_planner dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_strobe (out_strobe),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  adcrp_plan_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_data        (in_data),
    .out_strobe     (out_strobe),
    .out_data       (out_data),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .drain_done     (drain_done),
    .mismatch_count (mismatch_count),
    .plans_pending  (plans_pending)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Hard stop for a hung run
  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic adcrp_pkg::in_t pack_item(input logic signed [31:0] rate,
                                               input logic [19:0] count);
    adcrp_pkg::in_t beat;
    beat.rate_hz      = rate;
    beat.sample_count = count;
    return beat;
  endfunction

  function automatic adcrp_pkg::in_t noise_item();
    return pack_item($urandom, 20'($urandom));
  endfunction

  // Draw one request, mostly well formed and aimed at the decision edges
  function automatic adcrp_pkg::in_t random_item(input logic [31:0] bus_hz);
    adcrp_pkg::in_t beat;
    logic [63:0]    rate_mark;
    int unsigned    kind;
    int unsigned    fit_limit;
    kind = $urandom_range(99);
    beat.sample_count = ($urandom_range(3) == 0) ? 20'(1 << $urandom_range(15))
                                                 : 20'($urandom_range(1, 65535));
    rate_mark = 64'($urandom >> $urandom_range(1, 31));
    if (kind < 45) begin
      // log-spread positive rate
    end else if (kind < 65) begin
      // straddle a sample-time boundary
      case ($urandom_range(7))
        0: fit_limit = 28;
        1: fit_limit = 40;
        2: fit_limit = 52;
        3: fit_limit = 82;
        4: fit_limit = 108;
        5: fit_limit = 136;
        6: fit_limit = 168;
        default: fit_limit = 504;
      endcase
      rate_mark = ({32'd0, bus_hz} / 64'd8) * 64'd2 / 64'(fit_limit)
                  + 64'($urandom_range(2));
      rate_mark = (rate_mark > 64'd1) ? rate_mark - 64'd1 : 64'd1;
    end else if (kind < 80) begin
      // straddle a prescaler step
      rate_mark = {32'd0, bus_hz >> 16} / 64'($urandom_range(1, 64))
                  + 64'($urandom_range(2));
      rate_mark = (rate_mark > 64'd1) ? rate_mark - 64'd1 : 64'd1;
    end else if (kind < 88) begin
      beat.sample_count = ($urandom_range(1) == 0) ? 20'd0
                                                   : 20'($urandom_range(65536, 1048575));
    end else if (kind < 94) begin
      rate_mark = 64'd0;
    end
    if (rate_mark == 64'd0 && kind < 88) begin
      rate_mark = 64'd1;
    end
    if (rate_mark > 64'h7FFF_FFFF) begin
      rate_mark = 64'h7FFF_FFFF;
    end
    beat.rate_hz = rate_mark[31:0];
    if (kind >= 88 && kind < 94) begin
      // zero or negative rate
      beat.rate_hz = ($urandom_range(3) == 0) ? 32'sd0
                                              : 32'(-$signed({1'b0, $urandom} >> 1));
    end else if (kind >= 94) begin
      beat = noise_item();
    end
    return beat;
  endfunction

  // Present one request and hold it until the block takes the beat
  task automatic send_item(input adcrp_pkg::in_t beat);
    @(negedge clk);
    start   <= 1'b1;
    in_data <= beat;
    do @(posedge clk); while (busy);
  endtask

  // Drop start for the requested number of cycles with junk on the data lines
  task automatic idle_gap(input int unsigned cycles);
    repeat (cycles) begin
      @(negedge clk);
      start   <= 1'b0;
      in_data <= noise_item();
    end
  endtask

  task automatic maybe_idle();
    if (!quiet && $urandom_range(99) < 18) begin
      idle_gap($urandom_range(1, 5));
    end
  endtask

  // Drain all outstanding plans, then write the bus clock register
  task automatic write_clock(input logic [31:0] hz);
    @(negedge clk);
    start <= 1'b0;
    while (plans_pending != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= hz;
    @(negedge clk);
    cfg_we    <= 1'b0;
    clock_setting = hz;
  endtask

  initial begin
    int unsigned phase_items;
    rst_n         = 1'b0;
    start         = 1'b0;
    in_data       = '0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    drain_done    = 1'b0;
    quiet         = 1'b0;
    clock_setting = adcrp_pkg::CLK_RESET_HZ;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // Directed requests at the reset clock of 100 MHz
    send_item(pack_item(32'sd1000, 20'd0));
    send_item(pack_item(32'sd1000, 20'd65536));
    send_item(pack_item(32'sd1000, 20'hFFFFF));
    send_item(pack_item(-32'sd5, 20'd0));             // count wins over rate
    send_item(pack_item(32'sd0, 20'd1));
    send_item(pack_item(-32'sd1, 20'd1));
    send_item(pack_item(32'sh8000_0000, 20'd65535));
    send_item(pack_item(32'sh7FFF_FFFF, 20'd65535));
    send_item(pack_item(32'sd892858, 20'd100));       // just too fast
    send_item(pack_item(32'sd892857, 20'd100));       // shortest sample time fits
    send_item(pack_item(32'sd49604, 20'd100));
    send_item(pack_item(32'sd49603, 20'd100));        // longest sample time fits
    send_item(pack_item(32'sd1, 20'd1));              // slowest rate, top prescaler
    send_item(pack_item(32'sd1525, 20'd65535));       // prescaler step
    send_item(pack_item(32'sd1526, 20'd65535));
    send_item(pack_item(32'sd44100, 20'd4096));
    send_item(pack_item(32'sd1000, 20'd1));
    send_item(pack_item(32'sd2, 20'd2));

    // Random requests over a range of bus clocks, extremes included
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        1: write_clock(32'd1);
        2: write_clock(32'd0);
        3: write_clock(32'hFFFF_FFFF);
        4: write_clock(32'd72_000_000);
        5: write_clock(32'd8_000_000);
        6: write_clock($urandom);
        7: write_clock(adcrp_pkg::CLK_RESET_HZ);
        default: ;
      endcase
      quiet = (phase == 4);
      phase_items = (phase == 1 || phase == 2) ? 60 : 270;
      repeat (phase_items) begin
        maybe_idle();
        send_item(random_item(clock_setting));
      end
    end

    // Let the last plans land, then look for stragglers
    @(negedge clk);
    start <= 1'b0;
    while (plans_pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    @(negedge clk);
    drain_done <= 1'b1;
    repeat (3) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/adcrp_pkg.sv
hw/rtl/adcrp_div.sv
hw/rtl/adc_capture_rate_planner.sv
test/adcrp_plan_checker.sv
test/adc_capture_rate_planner_tb.sv
